FILE: rtl/dg_maxwell_face_flux_unit_assert.svh
// Assertion macros for the Maxwell face flux unit.
`ifndef DG_MAXWELL_FACE_FLUX_UNIT_ASSERT_SVH
`define DG_MAXWELL_FACE_FLUX_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGMFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgmff: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DGMFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgmff: next-cycle check failed");

`endif

FILE: rtl/dgmff_pkg.sv
// Constants shared by the Maxwell face flux unit.
`timescale 1ns / 1ps

package dgmff_pkg;

    // Default width of one field component (Q3.12 at 16 bits).
    localparam int COMPONENT_WIDTH_DEF = 16;
    // Integer bits of a component, sign included; the rest are fraction bits.
    localparam int INT_BITS = 4;
    // Face scale: signed Q7.8.
    localparam int SCALE_WIDTH = 16;
    localparam int SCALE_FRAC = 8;
    // Boundary factor: signed Q3.12.
    localparam int FACTOR_WIDTH = 16;
    localparam int FACTOR_FRAC = 12;
    // Number of register stages from input to output.
    localparam int PIPE_STAGES = 8;

endpackage

FILE: rtl/dg_maxwell_face_flux_unit.sv
// Maxwell upwind face flux unit: an eight-stage fixed-point pipeline.
// An accepted input beat passes through the stage registers in order to its result beat.
// Throughput: one beat per cycle when not stalled; each of the eight stages has its own valid bit.
// A stage moves on when its successor is empty or moving, so bubbles close up.
// Reset (synchronous, active low) clears the valid bits only; datapath registers are not reset.
`timescale 1ns / 1ps
`include "dg_maxwell_face_flux_unit_assert.svh"

module dg_maxwell_face_flux_unit #(
    parameter int COMPONENT_WIDTH = dgmff_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Input channel
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_h_minus,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_e_minus,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_h_plus,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_e_plus,
    input  logic signed [dgmff_pkg::SCALE_WIDTH-1:0]   i_face_scale,
    input  logic signed [dgmff_pkg::FACTOR_WIDTH-1:0]  i_boundary_factor,
    input  logic [3*COMPONENT_WIDTH-1:0]               i_normal,
    input  logic                                       i_remote_neighbour,
    // Output channel
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic [3*COMPONENT_WIDTH-1:0]               o_flux_h,
    output logic [3*COMPONENT_WIDTH-1:0]               o_flux_e
);

    import dgmff_pkg::*;

    // Component format and the growth of every intermediate value.
    localparam int W    = COMPONENT_WIDTH;
    localparam int F    = W - INT_BITS;           // fraction bits of a component
    localparam int VW   = 3 * W;                  // packed vector width
    localparam int NS   = PIPE_STAGES;
    localparam int BPW  = FACTOR_WIDTH + W;       // boundary factor times E+
    localparam int EW   = W + 4;                  // neighbour E after the factor
    localparam int DHRW = W + 1;                  // raw H jump
    localparam int DERW = EW + 1;                 // raw E jump
    localparam int DHPW = SCALE_WIDTH + DHRW;     // scaled H jump before rounding
    localparam int DEPW = SCALE_WIDTH + DERW;     // scaled E jump before rounding
    localparam int JW   = W + 14;                 // rounded jump, F fraction bits
    localparam int PW   = W + JW;                 // normal times jump, 2F fraction bits
    localparam int CW   = PW + 1;                 // cross product component
    localparam int DW   = PW + 2 - F;             // rounded normal dot jump
    localparam int NW   = DW + W;                 // dot times normal component
    localparam int SW   = 2 * W + 22;             // final component sum

    localparam int HALF_B = 1 << (FACTOR_FRAC - 1);
    localparam int HALF_S = 1 << (SCALE_FRAC - 1);
    localparam int HALF_F = 1 << (F - 1);

    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // Clamp a final component into W bits.
    function automatic logic [W-1:0] sat_comp(input logic signed [SW-1:0] v);
        logic [W-1:0] res;
        if (v[SW-1:W-1] == '0 || v[SW-1:W-1] == '1) begin
            res = v[W-1:0];
        end else if (v[SW-1]) begin
            res = SAT_MIN;
        end else begin
            res = SAT_MAX;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Flow control. Each stage holds one beat and a valid bit; a stage
    // loads when it is empty or when its own contents move on.
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, raw H jump, boundary factor product on E+.
    // ------------------------------------------------------------------
    logic signed [DHRW-1:0]         n1_dh_raw [3];
    logic signed [BPW-1:0]          n1_bprod [3];
    logic signed [W-1:0]            n1_ep [3];
    logic signed [W-1:0]            n1_em [3];
    logic signed [W-1:0]            n1_n [3];
    logic signed [DHRW-1:0]         r1_dh_raw [3];
    logic signed [BPW-1:0]          r1_bprod [3];
    logic signed [W-1:0]            r1_ep [3];
    logic signed [W-1:0]            r1_em [3];
    logic signed [W-1:0]            r1_n [3];
    logic                           r1_remote;
    logic signed [SCALE_WIDTH-1:0]  r1_fsc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_ep[i]     = signed'(i_e_plus[i*W +: W]);
            n1_em[i]     = signed'(i_e_minus[i*W +: W]);
            n1_n[i]      = signed'(i_normal[i*W +: W]);
            n1_dh_raw[i] = DHRW'(signed'(i_h_plus[i*W +: W]))
                         - DHRW'(signed'(i_h_minus[i*W +: W]));
            n1_bprod[i]  = BPW'(i_boundary_factor) * BPW'(n1_ep[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dh_raw <= n1_dh_raw;
            r1_bprod  <= n1_bprod;
            r1_ep     <= n1_ep;
            r1_em     <= n1_em;
            r1_n      <= n1_n;
            r1_remote <= i_remote_neighbour;
            r1_fsc    <= i_face_scale;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: neighbour E (factor applied only for a local neighbour),
    // raw E jump, and the face scale on the H jump.
    // ------------------------------------------------------------------
    logic signed [BPW:0]            n2_bsum [3];
    logic signed [EW-1:0]           n2_enb [3];
    logic signed [DERW-1:0]         n2_de_raw [3];
    logic signed [DHPW-1:0]         n2_dh_prod [3];
    logic signed [DERW-1:0]         r2_de_raw [3];
    logic signed [DHPW-1:0]         r2_dh_prod [3];
    logic signed [W-1:0]            r2_n [3];
    logic signed [SCALE_WIDTH-1:0]  r2_fsc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_bsum[i]    = (BPW+1)'(r1_bprod[i]) + (BPW+1)'(HALF_B);
            n2_enb[i]     = r1_remote ? EW'(r1_ep[i]) : EW'(n2_bsum[i] >>> FACTOR_FRAC);
            n2_de_raw[i]  = DERW'(n2_enb[i]) - DERW'(r1_em[i]);
            n2_dh_prod[i] = DHPW'(r1_fsc) * DHPW'(r1_dh_raw[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_de_raw  <= n2_de_raw;
            r2_dh_prod <= n2_dh_prod;
            r2_n       <= r1_n;
            r2_fsc     <= r1_fsc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the H jump, face scale on the E jump.
    // ------------------------------------------------------------------
    logic signed [DHPW:0]           n3_dh_sum [3];
    logic signed [JW-1:0]           n3_dh [3];
    logic signed [DEPW-1:0]         n3_de_prod [3];
    logic signed [JW-1:0]           r3_dh [3];
    logic signed [DEPW-1:0]         r3_de_prod [3];
    logic signed [W-1:0]            r3_n [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_dh_sum[i]  = (DHPW+1)'(r2_dh_prod[i]) + (DHPW+1)'(HALF_S);
            n3_dh[i]      = JW'(n3_dh_sum[i] >>> SCALE_FRAC);
            n3_de_prod[i] = DEPW'(r2_fsc) * DEPW'(r2_de_raw[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_dh      <= n3_dh;
            r3_de_prod <= n3_de_prod;
            r3_n       <= r2_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round the E jump. Both jumps now carry F fraction bits.
    // ------------------------------------------------------------------
    logic signed [DEPW:0]           n4_de_sum [3];
    logic signed [JW-1:0]           n4_de [3];
    logic signed [JW-1:0]           r4_dh [3];
    logic signed [JW-1:0]           r4_de [3];
    logic signed [W-1:0]            r4_n [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_de_sum[i] = (DEPW+1)'(r3_de_prod[i]) + (DEPW+1)'(HALF_S);
            n4_de[i]     = JW'(n4_de_sum[i] >>> SCALE_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_dh <= r3_dh;
            r4_de <= n4_de;
            r4_n  <= r3_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: every normal component times every jump component. The
    // diagonal feeds the dot products, the rest the cross products.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]           n5_ph [3][3];
    logic signed [PW-1:0]           n5_pe [3][3];
    logic signed [PW-1:0]           r5_ph [3][3];
    logic signed [PW-1:0]           r5_pe [3][3];
    logic signed [JW-1:0]           r5_dh [3];
    logic signed [JW-1:0]           r5_de [3];
    logic signed [W-1:0]            r5_n [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                n5_ph[j][k] = PW'(r4_n[j]) * PW'(r4_dh[k]);
                n5_pe[j][k] = PW'(r4_n[j]) * PW'(r4_de[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_ph <= n5_ph;
            r5_pe <= n5_pe;
            r5_dh <= r4_dh;
            r5_de <= r4_de;
            r5_n  <= r4_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: rounded dot products and unrounded cross products.
    // ------------------------------------------------------------------
    logic signed [PW+1:0]           n6_dsum_h;
    logic signed [PW+1:0]           n6_dsum_e;
    logic signed [CW-1:0]           n6_cx_de [3];
    logic signed [CW-1:0]           n6_cx_dh [3];
    logic signed [DW-1:0]           r6_ndot_h;
    logic signed [DW-1:0]           r6_ndot_e;
    logic signed [CW-1:0]           r6_cx_de [3];
    logic signed [CW-1:0]           r6_cx_dh [3];
    logic signed [JW-1:0]           r6_dh [3];
    logic signed [JW-1:0]           r6_de [3];
    logic signed [W-1:0]            r6_n [3];

    always_comb begin
        n6_dsum_h = (PW+2)'(r5_ph[0][0]) + (PW+2)'(r5_ph[1][1])
                  + (PW+2)'(r5_ph[2][2]) + (PW+2)'(HALF_F);
        n6_dsum_e = (PW+2)'(r5_pe[0][0]) + (PW+2)'(r5_pe[1][1])
                  + (PW+2)'(r5_pe[2][2]) + (PW+2)'(HALF_F);
        // n x dE, used by the magnetic flux.
        n6_cx_de[0] = CW'(r5_pe[1][2]) - CW'(r5_pe[2][1]);
        n6_cx_de[1] = CW'(r5_pe[2][0]) - CW'(r5_pe[0][2]);
        n6_cx_de[2] = CW'(r5_pe[0][1]) - CW'(r5_pe[1][0]);
        // n x dH, used by the electric flux.
        n6_cx_dh[0] = CW'(r5_ph[1][2]) - CW'(r5_ph[2][1]);
        n6_cx_dh[1] = CW'(r5_ph[2][0]) - CW'(r5_ph[0][2]);
        n6_cx_dh[2] = CW'(r5_ph[0][1]) - CW'(r5_ph[1][0]);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_ndot_h <= DW'(n6_dsum_h >>> F);
            r6_ndot_e <= DW'(n6_dsum_e >>> F);
            r6_cx_de  <= n6_cx_de;
            r6_cx_dh  <= n6_cx_dh;
            r6_dh     <= r5_dh;
            r6_de     <= r5_de;
            r6_n      <= r5_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: normal component of each jump, (n.d) n.
    // ------------------------------------------------------------------
    logic signed [NW-1:0]           n7_nn_h [3];
    logic signed [NW-1:0]           n7_nn_e [3];
    logic signed [NW-1:0]           r7_nn_h [3];
    logic signed [NW-1:0]           r7_nn_e [3];
    logic signed [CW-1:0]           r7_cx_de [3];
    logic signed [CW-1:0]           r7_cx_dh [3];
    logic signed [JW-1:0]           r7_dh [3];
    logic signed [JW-1:0]           r7_de [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_nn_h[i] = NW'(r6_ndot_h) * NW'(r6_n[i]);
            n7_nn_e[i] = NW'(r6_ndot_e) * NW'(r6_n[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_nn_h  <= n7_nn_h;
            r7_nn_e  <= n7_nn_e;
            r7_cx_de <= r6_cx_de;
            r7_cx_dh <= r6_cx_dh;
            r7_dh    <= r6_dh;
            r7_de    <= r6_de;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: assemble each component at 2F fraction bits, round back to
    // F, saturate and pack. This register is the output register.
    //   flux_h = dH - (n.dH) n - n x dE
    //   flux_e = dE - (n.dE) n + n x dH
    // ------------------------------------------------------------------
    logic signed [SW-1:0]           n8_sum_h [3];
    logic signed [SW-1:0]           n8_sum_e [3];
    logic [VW-1:0]                  n8_flux_h;
    logic [VW-1:0]                  n8_flux_e;
    logic [VW-1:0]                  r8_flux_h;
    logic [VW-1:0]                  r8_flux_e;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n8_sum_h[i] = (SW'(r7_dh[i]) <<< F) - SW'(r7_nn_h[i])
                        - SW'(r7_cx_de[i]) + SW'(HALF_F);
            n8_sum_e[i] = (SW'(r7_de[i]) <<< F) - SW'(r7_nn_e[i])
                        + SW'(r7_cx_dh[i]) + SW'(HALF_F);
            n8_flux_h[i*W +: W] = sat_comp(n8_sum_h[i] >>> F);
            n8_flux_e[i*W +: W] = sat_comp(n8_sum_e[i] >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r8_flux_h <= n8_flux_h;
            r8_flux_e <= n8_flux_e;
        end
    end

    assign o_flux_h = r8_flux_h;
    assign o_flux_e = r8_flux_e;

    // ------------------------------------------------------------------
    // Checks on the flow control.
    // ------------------------------------------------------------------
    // The input is only held off when every stage is occupied.
    `DGMFF_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_stall, &r_v)
    // An output that is free lets the whole pipeline accept a beat.
    `DGMFF_ASSERT_SAME(a_free_output_takes_input, i_clk, i_rst_n, !(o_valid && i_stall), !o_stall)
    // A beat in the last internal stage reaches the output once it is free.
    `DGMFF_ASSERT_NEXT(a_last_stage_advances, i_clk, i_rst_n, r_v[NS-2] && !(o_valid && i_stall), o_valid)

endmodule
